[src/rwsf_pkg.sv]
// Package: shared types, constants and control structs for the register write shadow filter.
`timescale 1ns / 1ps

package rwsf_pkg;

   localparam int REG_COUNT = 256;
   localparam int CHANNELS  = 8;
   localparam int ADDR_W    = $clog2(REG_COUNT);
   localparam int CHAN_W    = $clog2(CHANNELS);
   localparam int ROW_W     = ADDR_W - CHAN_W;

   typedef logic [ADDR_W-1:0]   addr_type;
   typedef logic [7:0]          data_type;
   typedef logic [CHAN_W-1:0]   chan_type;
   typedef logic [ROW_W-1:0]    row_type;
   typedef logic [CHANNELS-1:0] chan_set_type;

   // table entry: valid flag and value
   typedef struct packed {
      logic     valid;
      data_type value;
   } entry_type;

   localparam logic      OP_WRITE      = 1'b0;
   localparam logic      OP_LOOP       = 1'b1;
   localparam addr_type  KEY_REG       = 8'h08;
   localparam addr_type  ALIAS_FROM    = 8'h19;
   localparam addr_type  ALIAS_TO      = 8'h1a;
   localparam addr_type  CHAN_BASE     = 8'h20;
   localparam addr_type  ADDR_LAST     = 8'hff;
   localparam data_type  KEYON_MASK    = 8'hf8;
   localparam data_type  UNKNOWN_VALUE = 8'hff;
   localparam entry_type CLEARED_ENTRY = {1'b0, UNKNOWN_VALUE};
   localparam row_type   ROW_FIRST     = CHAN_BASE[ADDR_W-1:CHAN_W];
   localparam row_type   ROW_LAST      = {ROW_W{1'b1}};

   // controller to datapath
   typedef struct packed {
      logic idle;
      logic take;
      logic clear_step;
      logic clear_all;
      logic key_out;
      logic load_row;
      logic scan_read;
      logic scan_commit;
      logic cur_read;
      logic cur_commit;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic req_valid;
      logic req_loop;
      logic act_now;
      logic out_free;
      logic differ;
      logic emit_cur;
      logic row_end;
      logic clear_end;
   } sts_type;

endpackage

[src/rwsf_channels.sv]
// Interfaces: request and response channels of the register write shadow filter.
`timescale 1ns / 1ps

interface rwsf_req_if;
   logic                valid;
   logic                ready;
   logic                operation;
   rwsf_pkg::addr_type  reg_address;
   rwsf_pkg::data_type  reg_value;

   modport source (output valid, operation, reg_address, reg_value, input ready);
   modport sink   (input valid, operation, reg_address, reg_value, output ready);
endinterface

interface rwsf_rsp_if;
   logic                valid;
   logic                ready;
   rwsf_pkg::addr_type  out_address;
   rwsf_pkg::data_type  out_value;
   logic                last;

   modport source (output valid, out_address, out_value, last, input ready);
   modport sink   (input valid, out_address, out_value, last, output ready);
endinterface

[src/rwsf_datapath.sv]
// Datapath: pending and shadow tables, active channel set, scan and clear counters, output register.
`timescale 1ns / 1ps

module rwsf_datapath (
   input  logic              clock,
   input  logic              reset,
   input  rwsf_pkg::cmd_type cmd,
   output rwsf_pkg::sts_type sts,
   rwsf_req_if.sink          req,
   rwsf_rsp_if.source        rsp
);
   import rwsf_pkg::*;

   entry_type    pend_mem [REG_COUNT];
   entry_type    shad_mem [REG_COUNT];
   chan_set_type active_ff, active_in;
   addr_type     clr_addr_ff;

   addr_type a_ff;
   data_type v_ff;
   chan_type chan_ff;
   logic     pass_ff;
   row_type  row_ff;

   entry_type pend_q_ff, shad_q_ff;

   logic     rsp_valid_ff, rsp_valid_in;
   addr_type out_addr_ff;
   data_type out_val_ff;
   logic     last_ff;

   addr_type     alias_addr;
   chan_type     req_chan;
   logic         keyon;
   chan_set_type new_active;
   logic         pass_now;
   addr_type     scan_addr;
   addr_type     rd_addr;
   logic         take_write;
   logic         shad_we;
   addr_type     shad_waddr;
   logic         pend_clr;
   logic         load_out;
   addr_type     load_addr;
   data_type     load_val;
   logic         load_last;
   data_type     pend_out_val;

   // input decode
   always_comb begin
      alias_addr = (req.reg_address == ALIAS_FROM && req.reg_value[7]) ? ALIAS_TO
                                                                         : req.reg_address;
      req_chan   = req.reg_value[CHAN_W-1:0];
      keyon      = (alias_addr == KEY_REG) && ((req.reg_value & KEYON_MASK) != '0);
      new_active = active_ff | (chan_set_type'(keyon) << req_chan);
      if (alias_addr < CHAN_BASE) begin
         pass_now = (alias_addr == KEY_REG) ? new_active[req_chan] : 1'b1;
      end else begin
         pass_now = active_ff[alias_addr[CHAN_W-1:0]];
      end
   end

   assign take_write = cmd.take && (req.operation == OP_WRITE);
   assign scan_addr  = {row_ff, chan_ff};
   assign rd_addr    = cmd.scan_read ? scan_addr : a_ff;

   assign sts.req_valid = req.valid;
   assign sts.req_loop  = (req.operation == OP_LOOP);
   assign sts.act_now   = keyon && !active_ff[req_chan];
   assign sts.out_free  = !rsp_valid_ff || rsp.ready;
   assign sts.differ    = (pend_q_ff.valid != shad_q_ff.valid) ||
                          (pend_q_ff.valid && shad_q_ff.valid &&
                           (pend_q_ff.value != shad_q_ff.value));
   assign sts.emit_cur  = pass_ff && ((a_ff == KEY_REG) || sts.differ);
   assign sts.row_end   = (row_ff == ROW_LAST);
   assign sts.clear_end = (clr_addr_ff == ADDR_LAST);

   assign req.ready = cmd.idle;

   // captured transaction and scan row
   always_ff @(posedge clock) begin
      if (take_write) begin
         a_ff    <= alias_addr;
         v_ff    <= req.reg_value;
         chan_ff <= req_chan;
         pass_ff <= pass_now;
      end
      if (cmd.load_row) begin
         row_ff <= ROW_FIRST;
      end else if (cmd.scan_commit) begin
         row_ff <= row_ff + row_type'(1);
      end
   end

   // table reads
   always_ff @(posedge clock) begin
      if (cmd.scan_read || cmd.cur_read) begin
         pend_q_ff <= pend_mem[rd_addr];
         shad_q_ff <= shad_mem[rd_addr];
      end
   end

   // table writes; the clearing pass walks one address per cycle
   assign shad_we    = (cmd.scan_commit && sts.differ) ||
                       (cmd.cur_commit && sts.emit_cur && (a_ff != KEY_REG));
   assign shad_waddr = cmd.scan_commit ? scan_addr : a_ff;
   assign pend_clr   = cmd.clear_all || (clr_addr_ff < CHAN_BASE) ||
                       active_ff[clr_addr_ff[CHAN_W-1:0]];

   always_ff @(posedge clock) begin
      if (cmd.clear_step) begin
         if (pend_clr) begin
            pend_mem[clr_addr_ff] <= CLEARED_ENTRY;
         end
         shad_mem[clr_addr_ff] <= CLEARED_ENTRY;
      end else begin
         if (take_write && (alias_addr != KEY_REG)) begin
            pend_mem[alias_addr] <= {1'b1, req.reg_value};
         end
         if (shad_we) begin
            shad_mem[shad_waddr] <= pend_q_ff;
         end
      end
   end

   always_comb begin
      active_in = active_ff;
      if (take_write) begin
         active_in = new_active;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff   <= '0;
         clr_addr_ff <= '0;
      end else begin
         active_ff <= active_in;
         if (cmd.clear_step) begin
            clr_addr_ff <= clr_addr_ff + addr_type'(1);
         end
      end
   end

   // output register
   assign pend_out_val = pend_q_ff.valid ? pend_q_ff.value : UNKNOWN_VALUE;

   always_comb begin
      load_out  = 1'b0;
      load_addr = a_ff;
      load_val  = v_ff;
      load_last = 1'b0;
      if (cmd.key_out) begin
         load_out  = 1'b1;
         load_addr = KEY_REG;
         load_val  = data_type'(chan_ff);
      end else if (cmd.scan_commit) begin
         load_out  = sts.differ;
         load_addr = scan_addr;
         load_val  = pend_out_val;
      end else if (cmd.cur_commit) begin
         load_out  = sts.emit_cur;
         load_addr = (a_ff == ALIAS_TO) ? ALIAS_FROM : a_ff;
         load_last = 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (load_out) begin
         out_addr_ff <= load_addr;
         out_val_ff  <= load_val;
         last_ff     <= load_last;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.out_address = out_addr_ff;
   assign rsp.out_value   = out_val_ff;
   assign rsp.last        = last_ff;

endmodule

[src/rwsf_ctrl.sv]
// Controller: state machine sequencing accept, table clearing, channel scan and current write.
`timescale 1ns / 1ps

module rwsf_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  rwsf_pkg::sts_type sts,
   output rwsf_pkg::cmd_type cmd
);
   import rwsf_pkg::*;

   typedef enum logic [7:0] {
      ST_IDLE     = 8'b00000001,
      ST_INIT     = 8'b00000010,
      ST_CLEAR    = 8'b00000100,
      ST_KEY      = 8'b00001000,
      ST_SCAN_RD  = 8'b00010000,
      ST_SCAN_CHK = 8'b00100000,
      ST_CUR_RD   = 8'b01000000,
      ST_CUR_CHK  = 8'b10000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.idle = 1'b1;
            if (sts.req_valid) begin
               cmd.take = 1'b1;
               if (sts.req_loop) begin
                  state_in = ST_CLEAR;
               end else begin
                  state_in = sts.act_now ? ST_KEY : ST_CUR_RD;
               end
            end
         end
         ST_INIT: begin
            cmd.clear_step = 1'b1;
            cmd.clear_all  = 1'b1;
            if (sts.clear_end) begin
               state_in = ST_IDLE;
            end
         end
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (sts.clear_end) begin
               state_in = ST_IDLE;
            end
         end
         ST_KEY: begin
            if (sts.out_free) begin
               cmd.key_out  = 1'b1;
               cmd.load_row = 1'b1;
               state_in     = ST_SCAN_RD;
            end
         end
         ST_SCAN_RD: begin
            cmd.scan_read = 1'b1;
            state_in      = ST_SCAN_CHK;
         end
         ST_SCAN_CHK: begin
            if (!sts.differ || sts.out_free) begin
               cmd.scan_commit = 1'b1;
               state_in        = sts.row_end ? ST_CUR_RD : ST_SCAN_RD;
            end
         end
         ST_CUR_RD: begin
            cmd.cur_read = 1'b1;
            state_in     = ST_CUR_CHK;
         end
         ST_CUR_CHK: begin
            if (!sts.emit_cur || sts.out_free) begin
               cmd.cur_commit = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[src/register_write_shadow_filter.sv]
// Top level: register write shadow filter, controller plus datapath.
//
//  channel   dir  payload                          handshake
//  req_      in   operation, reg_address, reg_value  valid / ready
//  rsp_      out  out_address, out_value, last       valid / ready
//
// A plain write is accepted, read from both tables (ST_CUR_RD) and checked (ST_CUR_CHK)
// before the next accept. A loop marker is accepted and then a pass marks table entries
// unknown, one address per cycle. A key-on that activates a channel first emits the key-off
// (ST_KEY), then reads and checks each channel register row (28 rows) in turn, paced by the
// single read port of each table. Reset is synchronous; a pass over all 256 addresses then
// clears both tables before ready rises. A full output register stalls the controller.
`timescale 1ns / 1ps

module register_write_shadow_filter (
   input logic        clock,
   input logic        reset,
   rwsf_req_if.sink   req_channel,
   rwsf_rsp_if.source rsp_channel
);
   import rwsf_pkg::*;

   cmd_type cmd;
   sts_type sts;

   rwsf_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .sts   (sts),
      .cmd   (cmd)
   );

   rwsf_datapath u_datapath (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .sts   (sts),
      .req   (req_channel),
      .rsp   (rsp_channel)
   );

endmodule

[tb/shadow_filter_checker.sv]
// Checker: predicts the filtered register writes and compares them with the response transactions.
`timescale 1ns / 1ps

module shadow_filter_checker (
   input  logic clock,
   input  logic reset,
   rwsf_req_if  req_mon,
   rwsf_rsp_if  rsp_mon,
   output int   mismatch_count,
   output int   writes_outstanding
);
   import rwsf_pkg::*;

   typedef struct packed {
      addr_type address;
      data_type value;
      logic     last;
   } chip_write_type;

   // bit 8 known, bits 7..0 value; unknown entries always hold this pattern
   localparam logic [8:0] UNKNOWN_ENTRY = {1'b0, UNKNOWN_VALUE};

   logic [8:0]     pending_table [REG_COUNT];
   logic [8:0]     shadow_table [REG_COUNT];
   chan_set_type   active_set;
   chip_write_type expected_writes [$];
   chip_write_type want;
   int             fail_tally = 0;

   assign mismatch_count = fail_tally;

   task automatic report_mismatch(input string what);
      $display("%0t ERROR %s", $time, what);
      fail_tally++;
   endtask

   task automatic predict_writes(input logic op, input addr_type addr_in, input data_type val);
      addr_type       addr;
      addr_type       idx;
      chan_type       chan;
      chan_set_type   prior;
      logic           passes;
      chip_write_type item;
      chip_write_type batch [$];
      if (op == OP_LOOP) begin
         for (int i = 0; i < REG_COUNT; i++) begin
            shadow_table[i] = UNKNOWN_ENTRY;
            if (i < CHAN_BASE || active_set[i % CHANNELS]) pending_table[i] = UNKNOWN_ENTRY;
         end
      end else begin
         addr  = addr_in;
         prior = active_set;
         if (addr == ALIAS_FROM && val[7]) addr = ALIAS_TO;
         if (addr == KEY_REG && (val & KEYON_MASK) != 0) active_set[val[CHAN_W-1:0]] = 1'b1;
         if (addr != KEY_REG) pending_table[addr] = {1'b1, val};
         if (addr < CHAN_BASE) passes = (addr == KEY_REG) ? active_set[val[CHAN_W-1:0]] : 1'b1;
         else passes = active_set[addr[CHAN_W-1:0]];
         if (prior != active_set) begin
            chan = val[CHAN_W-1:0];
            item = '{KEY_REG, data_type'(chan), 1'b0};
            batch.insert(batch.size(), item);
            for (int row = ROW_FIRST; row <= ROW_LAST; row++) begin
               idx = {row_type'(row), chan};
               if (pending_table[idx] != shadow_table[idx]) begin
                  item = '{idx, pending_table[idx][7:0], 1'b0};
                  batch.insert(batch.size(), item);
                  shadow_table[idx] = pending_table[idx];
               end
            end
         end
         if (passes && (addr == KEY_REG || pending_table[addr] != shadow_table[addr])) begin
            if (addr != KEY_REG) shadow_table[addr] = pending_table[addr];
            item = '{(addr == ALIAS_TO) ? ALIAS_FROM : addr, val, 1'b0};
            batch.insert(batch.size(), item);
         end
         if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
         foreach (batch[k]) expected_writes.insert(expected_writes.size(), batch[k]);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < REG_COUNT; i++) begin
            pending_table[i] = UNKNOWN_ENTRY;
            shadow_table[i]  = UNKNOWN_ENTRY;
         end
         active_set = '0;
         expected_writes.delete();
      end else begin
         if (req_mon.valid && req_mon.ready)
            predict_writes(req_mon.operation, req_mon.reg_address, req_mon.reg_value);
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_writes.size() == 0) begin
               report_mismatch($sformatf("unexpected write %h=%h last %b",
                  rsp_mon.out_address, rsp_mon.out_value, rsp_mon.last));
            end else begin
               want = expected_writes.pop_front();
               if (rsp_mon.out_address !== want.address)
                  report_mismatch($sformatf("out_address %h, want %h",
                     rsp_mon.out_address, want.address));
               if (rsp_mon.out_value !== want.value)
                  report_mismatch($sformatf("out_value %h, want %h (addr %h)",
                     rsp_mon.out_value, want.value, want.address));
               if (rsp_mon.last !== want.last)
                  report_mismatch($sformatf("last %b, want %b (addr %h)",
                     rsp_mon.last, want.last, want.address));
            end
         end
      end
      writes_outstanding <= expected_writes.size();
   end

endmodule

[tb/testbench.sv]
// Testbench top: clock, reset, stimulus and verdict for the register write shadow filter.
`timescale 1ns / 1ps

module testbench;
   import rwsf_pkg::*;

   logic         clock;
   logic         reset;
   int           mismatch_count;
   int           writes_outstanding;
   int           hold_off_cycles = 0;
   int           items_sent = 0;
   bit           steady = 1'b0;
   chan_set_type keyed_on = '0;

   rwsf_req_if req_bus ();
   rwsf_rsp_if rsp_bus ();

   register_write_shadow_filter i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_channel (req_bus),
      .rsp_channel (rsp_bus)
   );

   shadow_filter_checker i_checker (
      .clock              (clock),
      .reset              (reset),
      .req_mon            (req_bus),
      .rsp_mon            (rsp_bus),
      .mismatch_count     (mismatch_count),
      .writes_outstanding (writes_outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #4_000_000;
      $display("Mismatches found");
      $finish;
   end

   task automatic send_item(input logic op, input addr_type addr, input data_type val);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.operation   <= op;
      req_bus.reg_address <= addr;
      req_bus.reg_value   <= val;
      do @(posedge clock); while (!req_bus.ready);
      items_sent++;
      if (op == OP_WRITE && addr == KEY_REG && (val & KEYON_MASK) != 0)
         keyed_on[val[CHAN_W-1:0]] = 1'b1;
   endtask

   // target < 0: no channel is being prepared for key-on
   task automatic send_mixed(input int target);
      int       kind;
      addr_type addr;
      data_type val;
      chan_type chan;
      kind = $urandom_range(0, 19);
      val  = ($urandom_range(0, 2) == 0) ? data_type'($urandom_range(0, 3) * 8'h55)
                                          : data_type'($urandom);
      chan = (target >= 0) ? chan_type'(target) : chan_type'($urandom_range(0, CHANNELS - 1));
      if (kind <= 8) begin
         send_item(OP_WRITE, {row_type'($urandom_range(ROW_FIRST, ROW_LAST)), chan}, val);
      end else if (kind <= 12) begin
         addr = addr_type'($urandom_range(0, CHAN_BASE - 1));
         if (addr == KEY_REG) addr = ALIAS_FROM;
         send_item(OP_WRITE, addr, val);
      end else if (kind <= 15) begin
         send_item(OP_WRITE, addr_type'($urandom_range(CHAN_BASE, REG_COUNT - 1)), val);
      end else if (kind <= 17) begin
         chan = chan_type'($urandom_range(0, CHANNELS - 1));
         val  = keyed_on[chan] ? {5'($urandom), chan} : {5'b0, chan};
         send_item(OP_WRITE, KEY_REG, val);
      end else if (kind == 18) begin
         send_item(OP_LOOP, addr_type'($urandom), data_type'($urandom));
      end else begin
         addr = addr_type'($urandom);
         val  = data_type'($urandom);
         if (addr == KEY_REG && !keyed_on[val[CHAN_W-1:0]]) val[7:CHAN_W] = '0;
         send_item(OP_WRITE, addr, val);
      end
   endtask

   initial begin
      int gap;
      rsp_bus.ready = 1'b0;
      forever begin
         gap = steady ? 0 : $urandom_range(0, 6);
         if (hold_off_cycles > 0) begin
            gap = hold_off_cycles;
            hold_off_cycles = 0;
         end
         if (gap > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid || reset);
      end
   end

   initial begin
      int  waiting [$];
      int  pick;
      int  target;
      bit  full_rows;
      req_bus.valid       = 1'b0;
      req_bus.operation   = OP_WRITE;
      req_bus.reg_address = '0;
      req_bus.reg_value   = '0;
      reset = 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // globals, duplicate suppression, 0x19/0x1a aliasing
      send_item(OP_WRITE, 8'h00, 8'h00);
      send_item(OP_WRITE, 8'h00, 8'h00);
      send_item(OP_WRITE, 8'h1f, 8'hff);
      send_item(OP_WRITE, ALIAS_FROM, 8'h7f);
      send_item(OP_WRITE, ALIAS_FROM, 8'h80);
      send_item(OP_WRITE, ALIAS_TO, 8'h80);
      send_item(OP_WRITE, ALIAS_TO, 8'h81);
      // held writes to inactive channels, key-off of inactive channels
      send_item(OP_WRITE, 8'h20, 8'h12);
      send_item(OP_WRITE, 8'hf8, 8'h34);
      send_item(OP_WRITE, 8'hff, 8'haa);
      send_item(OP_WRITE, KEY_REG, 8'h00);
      send_item(OP_WRITE, KEY_REG, 8'h07);
      // activation of channel 0, then key writes on an active channel
      send_item(OP_WRITE, KEY_REG, 8'hf8);
      send_item(OP_WRITE, KEY_REG, 8'h08);
      send_item(OP_WRITE, KEY_REG, 8'h00);
      send_item(OP_WRITE, 8'h20, 8'h12);
      send_item(OP_WRITE, 8'h20, 8'hed);
      send_item(OP_WRITE, 8'h21, 8'h55);
      // loop markers forget the shadow
      send_item(OP_LOOP, 8'hff, 8'hff);
      send_item(OP_WRITE, 8'h20, 8'hed);
      send_item(OP_WRITE, 8'h00, 8'h00);
      send_item(OP_LOOP, 8'h00, 8'h00);
      send_item(OP_WRITE, KEY_REG, 8'h81);
      send_item(OP_WRITE, 8'h21, 8'h55);
      send_item(OP_WRITE, 8'hff, 8'haa);

      // one phase per remaining channel: registers (first phase only), noise, then the key-on
      for (int c = 0; c < CHANNELS; c++)
         if (!keyed_on[c]) waiting.insert(waiting.size(), c);
      full_rows = 1'b1;
      while (waiting.size() > 0) begin
         pick   = $urandom_range(0, waiting.size() - 1);
         target = waiting[pick];
         waiting.delete(pick);
         steady = ($urandom_range(0, 3) == 0);
         if (full_rows) begin
            steady = 1'b0;
            for (int row = ROW_FIRST; row <= ROW_LAST; row++)
               send_item(OP_WRITE, {row_type'(row), chan_type'(target)}, data_type'($urandom));
            hold_off_cycles = 300;
         end
         repeat ($urandom_range(8, 18)) send_mixed(target);
         if (!keyed_on[target])
            send_item(OP_WRITE, KEY_REG, {5'($urandom_range(1, 31)), chan_type'(target)});
         full_rows = 1'b0;
      end

      while (items_sent < 210) begin
         if (items_sent % 25 == 0) steady = ($urandom_range(0, 3) == 0);
         send_mixed(-1);
      end
      req_bus.valid <= 1'b0;
      steady = 1'b0;

      do @(posedge clock); while (writes_outstanding != 0);
      repeat (64) @(posedge clock);
      if (mismatch_count == 0 && writes_outstanding == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
